>>> hdl/batchnorm_inference_scale_shift_macros.svh
// Assertion macros shared by the batch normalization scale/shift block
`ifndef BATCHNORM_INFERENCE_SCALE_SHIFT_MACROS_SVH
`define BATCHNORM_INFERENCE_SCALE_SHIFT_MACROS_SVH
`ifndef ASSERT_OFF
`define BNSS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bnss assertion failed");
`define BNSS_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("bnss forbidden condition");
`else
`define BNSS_ASSERT(lbl, clk, rst_n, prop)
`define BNSS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hdl/bnss_pkg.sv
// Shared constants and types of the batch normalization scale/shift block
package bnss_pkg;
	localparam int D_W         = 25;
	localparam int QUOT_W      = 50;
	localparam int NUM_MSB     = 48;
	localparam int ROOT_W      = 25;
	localparam int SREM_W      = ROOT_W + 3;
	localparam int SCALE_W     = 41;
	localparam int SCALE_FRAC  = 28;
	localparam int DIFF_W      = 17;
	localparam int SPLIT       = 21;
	localparam int PROD_W      = DIFF_W + SCALE_W;
	localparam int Q_W         = PROD_W - SCALE_FRAC;
	localparam int SUM_W       = Q_W + 1;
	localparam int CFG_IDX_W   = 1;

	localparam logic signed [15:0] GAMMA_ONE = 16'sd4096;
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_AFFINE  = 1'b1;

	typedef struct packed {
		logic        valid;
		logic        in_range;
		logic [7:0]  channel;
		logic signed [15:0] sample;
	} smp_req_t;

	typedef struct packed {
		logic signed [15:0]        mean;
		logic signed [SCALE_W-1:0] scale;
		logic signed [15:0]        offset;
	} entry_t;

	typedef struct packed {
		logic       en;
		logic [7:0] channel;
		entry_t     data;
	} mem_wr_t;

	typedef struct packed {
		logic           start;
		logic [D_W-1:0] denom;
	} root_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} root_rsp_t;
endpackage

>>> hdl/bnss_inv_root.sv
// Iterative inverse square root: 2^48 / d by restoring division, then bitwise integer root
`include "batchnorm_inference_scale_shift_macros.svh"
module bnss_inv_root (
	input  logic                clk,
	input  logic                arst_n,
	input  bnss_pkg::root_req_t req,
	output bnss_pkg::root_rsp_t rsp
);
	import bnss_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;

	logic [1:0]        state_q;
	logic [5:0]        cnt_q;
	logic              done_q;
	logic [D_W-1:0]    den_q;
	logic [D_W-1:0]    drem_q;
	logic [QUOT_W-1:0] quot_q;
	logic [ROOT_W-1:0] root_q;
	logic [SREM_W-1:0] srem_q;

	logic [D_W:0]      dshift;
	logic              dge;
	logic [D_W:0]      dnext;
	logic [SREM_W-1:0] sshift;
	logic [SREM_W-1:0] strial;
	logic              sge;
	logic [SREM_W-1:0] snext;

	always_comb begin
		dshift = {drem_q, (cnt_q == 6'(NUM_MSB)) && (state_q == ST_DIV)};
		dge    = dshift >= {1'b0, den_q};
		dnext  = dge ? (dshift - {1'b0, den_q}) : dshift;
		sshift = {srem_q[ROOT_W:0], quot_q[QUOT_W-1 -: 2]};
		strial = {1'b0, root_q, 2'b01};
		sge    = sshift >= strial;
		snext  = sge ? (sshift - strial) : sshift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= ST_DIV;
						cnt_q   <= 6'(NUM_MSB);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
						cnt_q   <= 6'(ROOT_W - 1);
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				den_q  <= (req.denom == '0) ? D_W'(1) : req.denom;
				drem_q <= '0;
				quot_q <= '0;
				root_q <= '0;
				srem_q <= '0;
			end
			ST_DIV: begin
				drem_q <= dnext[D_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], dge};
			end
			ST_SQRT: begin
				srem_q <= snext;
				root_q <= {root_q[ROOT_W-2:0], sge};
				quot_q <= {quot_q[QUOT_W-3:0], 2'b00};
			end
			default: begin
				quot_q <= quot_q;
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

	`BNSS_ASSERT(a_done_after_sqrt, clk, arst_n, rsp.done |-> $past(state_q == ST_SQRT))
	`BNSS_ASSERT(a_start_when_idle, clk, arst_n, req.start |-> (state_q == ST_IDLE))
endmodule

>>> hdl/bnss_norm_pipe.sv
// Channel parameter memory and the pipelined sample normalization datapath
`include "batchnorm_inference_scale_shift_macros.svh"
module bnss_norm_pipe #(
	parameter int CHANNELS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bnss_pkg::smp_req_t req,
	input  bnss_pkg::mem_wr_t  wr,
	output logic               adv,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] result,
	output logic [7:0]         result_channel,
	output logic               saturated
);
	import bnss_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	entry_t param_mem [CHANNELS];

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic rng_s1, rng_s2, rng_s3, rng_s4;
	logic [7:0] ch_s1, ch_s2, ch_s3, ch_s4, result_channel_q;
	logic signed [15:0] smp_s1;
	entry_t rd_s1;
	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [SCALE_W-1:0] scale_s2;
	logic signed [15:0] off_s2, off_s3, off_s4;
	logic signed [DIFF_W+SPLIT:0] plo_s3;
	logic signed [DIFF_W+SCALE_W-SPLIT-1:0] phi_s3;
	logic signed [Q_W-1:0] q_s4;
	logic signed [PROD_W-1:0] prod;
	logic signed [SUM_W-1:0] sum;
	logic signed [15:0] result_q;
	logic saturated_q;

	assign adv = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			param_mem[AW'(wr.channel)] <= wr.data;
		end
		if (adv) begin
			rd_s1 <= param_mem[AW'(req.channel)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= req.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_comb begin
		prod = $signed({phi_s3, SPLIT'(0)}) + PROD_W'(plo_s3);
		sum  = SUM_W'(q_s4) + SUM_W'(off_s4);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rng_s1   <= req.in_range;
			ch_s1    <= req.channel;
			smp_s1   <= req.sample;

			rng_s2   <= rng_s1;
			ch_s2    <= ch_s1;
			diff_s2  <= DIFF_W'(smp_s1) - DIFF_W'(rd_s1.mean);
			scale_s2 <= rd_s1.scale;
			off_s2   <= rd_s1.offset;

			rng_s3   <= rng_s2;
			ch_s3    <= ch_s2;
			plo_s3   <= diff_s2 * $signed({1'b0, scale_s2[SPLIT-1:0]});
			phi_s3   <= diff_s2 * $signed(scale_s2[SCALE_W-1:SPLIT]);
			off_s3   <= off_s2;

			rng_s4   <= rng_s3;
			ch_s4    <= ch_s3;
			q_s4     <= prod[PROD_W-1:SCALE_FRAC];
			off_s4   <= off_s3;

			result_channel_q <= ch_s4;
			if (!rng_s4) begin
				result_q    <= '0;
				saturated_q <= 1'b0;
			end else if (sum > SUM_W'(32767)) begin
				result_q    <= 16'sh7FFF;
				saturated_q <= 1'b1;
			end else if (sum < -SUM_W'(32768)) begin
				result_q    <= 16'sh8000;
				saturated_q <= 1'b1;
			end else begin
				result_q    <= sum[15:0];
				saturated_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign result         = result_q;
	assign result_channel = result_channel_q;
	assign saturated      = saturated_q;

	`BNSS_ASSERT(a_req_only_on_advance, clk, arst_n, req.valid |-> adv)
	`BNSS_ASSERT(a_stall_holds_pipe, clk, arst_n, !adv |=> $stable(v_s4))
	`BNSS_ASSERT(a_s4_reaches_output, clk, arst_n, (v_s4 && adv) |=> out_valid)
endmodule

>>> hdl/batchnorm_inference_scale_shift.sv
// Top level of the per-channel batch normalization scale/shift block
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------------
//  in      | in_valid / in_ready  | action, channel, sample, param_mean/var/gamma/beta
//  out     | out_valid/ out_ready | result, result_channel, saturated
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
//  Samples: one transaction per cycle while in_ready is high, via stages s1 to s4.
//  Loads: busy in the divide/root unit (49 + 25 steps), the scale multiply and
//  the memory write; in_ready stays low meanwhile.
//  A stalled output freezes the whole sample pipeline, memory read register included.
//  Reset clears control state only; the parameter memory is undefined until loaded.
`include "batchnorm_inference_scale_shift_macros.svh"
module batchnorm_inference_scale_shift #(
	parameter int CHANNELS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [7:0]                       channel,
	input  logic signed [15:0]               sample,
	input  logic signed [15:0]               param_mean,
	input  logic [15:0]                      param_var,
	input  logic signed [15:0]               param_gamma,
	input  logic signed [15:0]               param_beta,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [15:0]               result,
	output logic [7:0]                       result_channel,
	output logic                             saturated,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bnss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                      cfg_data
);
	import bnss_pkg::*;

	localparam logic [1:0] L_IDLE  = 2'd0;
	localparam logic [1:0] L_ROOT  = 2'd1;
	localparam logic [1:0] L_WRITE = 2'd2;

	logic [1:0]  lstate_q;
	logic [15:0] epsilon_q;
	logic        affine_q;
	logic [7:0]  ld_ch_q;
	logic signed [15:0] ld_mean_q;
	logic signed [15:0] ld_gamma_q;
	logic signed [15:0] ld_beta_q;
	logic signed [SCALE_W-1:0] scale_q;

	logic      adv;
	logic      accept;
	logic      in_range;
	smp_req_t  smp_req;
	mem_wr_t   wr;
	root_req_t root_req;
	root_rsp_t root_rsp;

	assign cfg_ready = 1'b1;
	assign in_ready  = (lstate_q == L_IDLE) && adv;
	assign accept    = in_valid && in_ready;
	assign in_range  = {24'd0, channel} < 32'(CHANNELS);

	always_comb begin
		smp_req.valid    = accept && (action == ACT_SAMPLE);
		smp_req.in_range = in_range;
		smp_req.channel  = channel;
		smp_req.sample   = sample;

		root_req.start = accept && (action == ACT_LOAD) && in_range;
		root_req.denom = {1'b0, param_var, 8'd0} + D_W'(epsilon_q);

		wr.en          = (lstate_q == L_WRITE);
		wr.channel     = ld_ch_q;
		wr.data.mean   = ld_mean_q;
		wr.data.scale  = scale_q;
		wr.data.offset = ld_beta_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= 16'd1;
			affine_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EPSILON: epsilon_q <= cfg_data;
				REG_AFFINE:  affine_q  <= cfg_data[0];
				default:     epsilon_q <= epsilon_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lstate_q <= L_IDLE;
		end else begin
			unique case (lstate_q)
				L_IDLE:  if (root_req.start) lstate_q <= L_ROOT;
				L_ROOT:  if (root_rsp.done) lstate_q <= L_WRITE;
				L_WRITE: lstate_q <= L_IDLE;
				default: lstate_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (root_req.start) begin
			ld_ch_q    <= channel;
			ld_mean_q  <= param_mean;
			ld_gamma_q <= affine_q ? param_gamma : GAMMA_ONE;
			ld_beta_q  <= affine_q ? param_beta : 16'sd0;
		end
		if (root_rsp.done) begin
			scale_q <= SCALE_W'(ld_gamma_q * $signed({1'b0, root_rsp.root}));
		end
	end

	bnss_inv_root u_inv_root (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.rsp    (root_rsp)
	);

	bnss_norm_pipe #(
		.CHANNELS (CHANNELS)
	) u_norm_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (smp_req),
		.wr             (wr),
		.adv            (adv),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result         (result),
		.result_channel (result_channel),
		.saturated      (saturated)
	);

	`BNSS_ASSERT(a_write_after_root, clk, arst_n, wr.en |-> $past(root_rsp.done))
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the batch normalization scale/shift block
`timescale 1ns / 100ps

module tb_top;
	import bnss_pkg::*;

	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 300;

	typedef struct {
		logic               action;
		logic [7:0]         channel;
		logic signed [15:0] sample;
		logic signed [15:0] mean;
		logic [15:0]        variance;
		logic signed [15:0] gamma;
		logic signed [15:0] beta;
	} bn_item_t;

	typedef struct {
		logic signed [15:0] value;
		logic [7:0]         chan;
		logic               sat;
	} norm_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACT_LOAD;
	logic [7:0] channel = '0;
	logic signed [15:0] sample = '0;
	logic signed [15:0] param_mean = '0;
	logic [15:0] param_var = '0;
	logic signed [15:0] param_gamma = '0;
	logic signed [15:0] param_beta = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] result;
	logic [7:0] result_channel;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_EPSILON;
	logic [15:0] cfg_data = '0;

	logic signed [15:0] chan_mean [256];
	longint             scale_mem [256];
	logic signed [15:0] offset_mem [256];
	logic [15:0]        eps_reg = 16'd1;
	logic               affine_reg = 1'b1;
	bit                 loaded [256];
	int                 loaded_chans [$];

	norm_out_t pending_outputs [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int n_loads = 0;
	int n_samples = 0;
	int n_checked = 0;
	int n_sat = 0;
	int n_cfg = 0;

	batchnorm_inference_scale_shift DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.channel(channel),
		.sample(sample),
		.param_mean(param_mean),
		.param_var(param_var),
		.param_gamma(param_gamma),
		.param_beta(param_beta),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result(result),
		.result_channel(result_channel),
		.saturated(saturated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAIL batchnorm_inference_scale_shift");
		$finish;
	end

	function automatic longint unsigned inv_sqrt_q16(input longint unsigned denom);
		longint unsigned limit;
		longint unsigned root;
		longint unsigned trial;
		int b;
		root = 0;
		if (denom == 0)
			denom = 1;
		limit = (64'd1 << 48) / denom;
		for (b = ROOT_W - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= limit)
				root = trial;
		end
		return root;
	endfunction

	function automatic void store_channel(input bn_item_t it);
		longint unsigned denom;
		longint g;
		denom = (longint'(it.variance) << 8) + longint'(eps_reg);
		g = affine_reg ? longint'(it.gamma) : longint'(GAMMA_ONE);
		chan_mean[it.channel] = it.mean;
		scale_mem[it.channel] = g * longint'(inv_sqrt_q16(denom));
		offset_mem[it.channel] = affine_reg ? it.beta : 16'sd0;
		if (!loaded[it.channel]) begin
			loaded[it.channel] = 1'b1;
			loaded_chans.push_back(int'(it.channel));
		end
	endfunction

	function automatic norm_out_t normalize(input bn_item_t it);
		norm_out_t o;
		longint diff;
		longint sum;
		diff = longint'(it.sample) - longint'(chan_mean[it.channel]);
		sum = ((diff * scale_mem[it.channel]) >>> SCALE_FRAC)
			+ longint'(offset_mem[it.channel]);
		o.chan = it.channel;
		o.sat = 1'b0;
		if (sum > 32767) begin
			sum = 32767;
			o.sat = 1'b1;
		end else if (sum < -32768) begin
			sum = -32768;
			o.sat = 1'b1;
		end
		o.value = sum[15:0];
		return o;
	endfunction

	function automatic bn_item_t make_load(input logic [7:0] ch, input logic [15:0] mean,
			input logic [15:0] variance, input logic [15:0] gamma, input logic [15:0] beta);
		bn_item_t it;
		it.action = ACT_LOAD;
		it.channel = ch;
		it.sample = 16'($urandom);
		it.mean = mean;
		it.variance = variance;
		it.gamma = gamma;
		it.beta = beta;
		return it;
	endfunction

	function automatic bn_item_t make_sample(input logic [7:0] ch, input logic [15:0] s);
		bn_item_t it;
		it.action = ACT_SAMPLE;
		it.channel = ch;
		it.sample = s;
		it.mean = 16'($urandom);
		it.variance = 16'($urandom);
		it.gamma = 16'($urandom);
		it.beta = 16'($urandom);
		return it;
	endfunction

	task automatic issue_item(input bn_item_t it);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		action <= it.action;
		channel <= it.channel;
		sample <= it.sample;
		param_mean <= it.mean;
		param_var <= it.variance;
		param_gamma <= it.gamma;
		param_beta <= it.beta;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (it.action == ACT_LOAD) begin
			store_channel(it);
			n_loads++;
		end else begin
			pending_outputs.push_back(normalize(it));
			n_samples++;
		end
	endtask

	// hold off input until every expected transaction is back, then wait extra_cycles more
	task automatic drain_results(input int extra_cycles);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (extra_cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_EPSILON)
			eps_reg = data;
		else if (idx == REG_AFFINE)
			affine_reg = data[0];
		n_cfg++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_outputs.size() == 0) begin
					$display("%0t: unexpected transaction result=%0d channel=%0d sat=%0b",
						$time, result, result_channel, saturated);
					errors++;
				end else begin
					norm_out_t exp_out;
					exp_out = pending_outputs.pop_front();
					if (result !== exp_out.value) begin
						$display("%0t: result expected %0d actual %0d",
							$time, exp_out.value, result);
						errors++;
					end
					if (result_channel !== exp_out.chan) begin
						$display("%0t: result_channel expected %0d actual %0d",
							$time, exp_out.chan, result_channel);
						errors++;
					end
					if (saturated !== exp_out.sat) begin
						$display("%0t: saturated expected %0b actual %0b",
							$time, exp_out.sat, saturated);
						errors++;
					end
					if (exp_out.sat)
						n_sat++;
					n_checked++;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic test_directed_extremes();
		issue_item(make_load(8'd0, 16'sd0, 16'd0, GAMMA_ONE, 16'sd0));
		issue_item(make_sample(8'd0, 16'sd0));
		issue_item(make_sample(8'd0, 16'sd1));
		issue_item(make_sample(8'd0, -16'sd1));
		issue_item(make_sample(8'd0, 16'sh7FFF));
		issue_item(make_sample(8'd0, 16'sh8000));
		issue_item(make_load(8'd255, 16'sh8000, 16'hFFFF, 16'sh8000, 16'sh7FFF));
		issue_item(make_sample(8'd255, 16'sh7FFF));
		issue_item(make_sample(8'd255, 16'sh8000));
		issue_item(make_load(8'd128, 16'sh7FFF, 16'd0, 16'sh7FFF, 16'sh8000));
		issue_item(make_sample(8'd128, 16'sh8000));
		issue_item(make_sample(8'd128, 16'sh7FFF));
		// negative products with a remainder round toward minus infinity
		issue_item(make_load(8'd1, 16'sd0, 16'd1, -16'sd1, 16'sd0));
		issue_item(make_sample(8'd1, 16'sd1));
		issue_item(make_sample(8'd1, -16'sd3));
	endtask

	task automatic test_non_affine_and_epsilon();
		drain_results(DRAIN_CYCLES);
		write_reg(REG_AFFINE, 16'd0);
		write_reg(REG_EPSILON, 16'hFFFF);
		issue_item(make_load(8'd7, 16'($urandom), 16'd0, 16'sh8000, 16'sh7FFF));
		issue_item(make_sample(8'd7, 16'($urandom)));
		issue_item(make_sample(8'd7, 16'sh7FFF));
		issue_item(make_sample(8'd0, 16'sd1));
		drain_results(DRAIN_CYCLES);
		write_reg(REG_EPSILON, 16'd1);
		write_reg(REG_AFFINE, 16'd1);
		issue_item(make_load(8'd7, 16'($urandom), 16'hFFFF, 16'($urandom), 16'($urandom)));
		issue_item(make_sample(8'd7, 16'($urandom)));
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct,
			input logic [15:0] eps, input logic aff);
		logic [7:0] ch;
		logic signed [15:0] s;
		int n;
		drain_results(DRAIN_CYCLES);
		write_reg(REG_EPSILON, eps);
		write_reg(REG_AFFINE, {15'd0, aff});
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (loaded_chans.size() == 0 || $urandom_range(99) < 12) begin
				ch = 8'($urandom_range(255));
				issue_item(make_load(ch, 16'($urandom),
					($urandom_range(3) == 0) ? 16'($urandom_range(15)) : 16'($urandom),
					16'($urandom), 16'($urandom)));
			end else begin
				ch = 8'(loaded_chans[$urandom_range(loaded_chans.size() - 1)]);
				case ($urandom_range(3))
					0: s = chan_mean[ch] + 16'($urandom_range(64)) - 16'sd32;
					1: s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
					default: s = 16'($urandom);
				endcase
				issue_item(make_sample(ch, s));
			end
			if ($urandom_range(99) == 0)
				drain_results(0);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_random_traffic();
		run_random_phase(0, 0, 16'd1, 1'b1);
		run_random_phase(75, 0, 16'hFFFF, 1'b0);
		run_random_phase(0, 75, 16'($urandom_range(65535, 1)), 1'b1);
		run_random_phase(22, 22, 16'($urandom_range(65535, 1)), 1'($urandom_range(1)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_non_affine_and_epsilon();
		test_random_traffic();
		drain_results(DRAIN_CYCLES);
		$display("Sent %0d parameter loads and %0d samples over %0d register writes;",
			n_loads, n_samples, n_cfg);
		$display("checked %0d normalized results, %0d of them clipped.", n_checked, n_sat);
		if (errors == 0 && pending_outputs.size() == 0) begin
			$display("PASS batchnorm_inference_scale_shift");
		end else begin
			$display("FAIL batchnorm_inference_scale_shift");
		end
		$finish;
	end
endmodule
